// ----- hw/rtl/ugb_pkg.sv -----
// shared types and codes for the uniform grid broadphase
package ugb_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_ADD      = 2'd1,
		OP_NEIGHBOR = 2'd2,
		OP_BUCKET   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_LIMIT = 3'd2,
		ST_RANGE = 3'd3,
		ST_ZERO  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_EDGE_LEN = 2'd0,
		REG_COLUMNS  = 2'd1,
		REG_ROWS     = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_DIV,
		S_DISPATCH,
		S_FILL_RD,
		S_FILL_WAIT,
		S_FILL_USE,
		S_ENT_RD,
		S_ENT_WAIT,
		S_OUT_WAIT,
		S_FINISH
	} state_t;

	localparam int POS_BITS = 20;
	localparam int MAG_BITS = 19;
	localparam int CW_BITS  = 16;
	localparam int FILL_BITS = 3;

endpackage

// ----- hw/rtl/ugb_ram.sv -----
// generic single-port synchronous ram with registered read
module ugb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hw/rtl/ugb_divider.sv -----
// restoring divider, one quotient bit per cycle
module ugb_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ugb_pkg::MAG_BITS-1:0]    dividend,
	input  logic [ugb_pkg::CW_BITS-1:0]     divisor,
	output logic                            done,
	output logic [ugb_pkg::MAG_BITS-1:0]    quotient
);
	import ugb_pkg::*;

	logic [MAG_BITS-1:0] quo_q;
	logic [CW_BITS:0]    rem_q;
	logic [4:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [CW_BITS:0]    trial;
	logic [CW_BITS:0]    shifted;

	always_comb begin
		shifted = {rem_q[CW_BITS-1:0], quo_q[MAG_BITS-1]};
		trial   = shifted - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// quotient is complete the cycle after the last step
			done_q <= busy_q && (cnt_q == 5'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MAG_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[CW_BITS]) begin
				rem_q <= trial;
				quo_q <= {quo_q[MAG_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[MAG_BITS-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ----- hw/rtl/uniform_grid_broadphase.sv -----
// top level of the uniform grid broadphase with its sequencer
// usage:
//   in channel (in_valid/in_ready) takes one operation item at a time;
//   out channel (out_valid/out_ready) returns its results, last marks the end.
//   cfg channel (cfg_valid/cfg_ready) writes cell edge, columns, rows; write
//   only while idle.
// operation flow:
//   clear sweeps every cell fill entry.
//   add and neighbor query first run two divides for the cell
//   coordinates, x then y; add then reads the cell fill, writes the
//   entry and new fill, and finally loads its result.
//   a neighbor query reads the fill of each cell visited and then reads
//   each id returned; a bucket query skips the divides.
//   the single-port fill and entry memories set this order of steps.
// reset:
//   control state clears at once; then a clearing pass over every
//   cell zeroes the fill memory while in_ready is low.
// stall:
//   each result sits in an output register until transferred; the
//   sequencer waits while out_valid is high and out_ready low. in_ready
//   is high whenever the sequencer is idle.
module uniform_grid_broadphase #(
	parameter int MAX_COLUMNS   = 32,
	parameter int MAX_ROWS      = 32,
	parameter int CELL_CAPACITY = 7,
	parameter int ID_BITS       = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] element_id,
	input  logic signed [19:0] pos_x,
	input  logic signed [19:0] pos_y,
	input  logic [5:0]  bucket_row,
	input  logic [5:0]  bucket_col,
	input  logic [5:0]  result_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] found_id,
	output logic        id_valid,
	output logic [2:0]  status,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ugb_pkg::*;

	localparam int COL_BITS   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_BITS   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int NUM_CELLS  = MAX_COLUMNS * MAX_ROWS;
	localparam int CELL_BITS  = $clog2(NUM_CELLS) > 0 ? $clog2(NUM_CELLS) : 1;
	localparam int NUM_SLOTS  = NUM_CELLS * CELL_CAPACITY;
	localparam int SLOT_BITS  = $clog2(NUM_SLOTS) > 0 ? $clog2(NUM_SLOTS) : 1;
	localparam int STORE_BITS = (ID_BITS < 16) ? ID_BITS : 16;

	// configuration registers
	logic [15:0] edge_len_q;
	logic [5:0]  columns_q;
	logic [5:0]  rows_q;

	// effective grid size (0 acts as 1, clamp to maximum)
	logic [6:0] cols_eff;
	logic [6:0] rows_eff;
	logic [15:0] width_eff;

	always_comb begin
		if (columns_q == 6'd0) cols_eff = 7'd1;
		else if (7'(columns_q) > 7'(MAX_COLUMNS)) cols_eff = 7'(MAX_COLUMNS);
		else cols_eff = 7'(columns_q);
		if (rows_q == 6'd0) rows_eff = 7'd1;
		else if (7'(rows_q) > 7'(MAX_ROWS)) rows_eff = 7'(MAX_ROWS);
		else rows_eff = 7'(rows_q);
		width_eff = (edge_len_q == 16'd0) ? 16'd1 : edge_len_q;
	end

	// item registers
	op_t                 op_q;
	logic [STORE_BITS-1:0] id_q;
	logic [POS_BITS-1:0] px_q;
	logic [POS_BITS-1:0] py_q;
	logic [5:0]          brow_q;
	logic [5:0]          bcol_q;
	logic [5:0]          limit_q;

	state_t state_q, state_d;

	// coordinates, walk counters
	logic [COL_BITS-1:0] ccol_q;
	logic [ROW_BITS-1:0] crow_q;
	logic                div_y_q;
	logic [1:0]          dx_q, dy_q;
	logic [CELL_BITS-1:0] cell_q;
	logic [FILL_BITS-1:0] cnt_q;
	logic [FILL_BITS-1:0] slot_q;
	logic [6:0]          n_q;
	logic [CELL_BITS:0]  clr_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_id_q;
	logic        out_idv_q;
	logic [2:0]  out_st_q;
	logic        out_last_q;

	// memories
	logic                 fill_we;
	logic [CELL_BITS-1:0] fill_addr;
	logic [FILL_BITS-1:0] fill_wdata, fill_rdata;
	logic                 ent_we;
	logic [SLOT_BITS-1:0] ent_addr;
	logic [STORE_BITS-1:0] ent_wdata, ent_rdata;

	ugb_ram #(.WIDTH(FILL_BITS), .DEPTH(NUM_CELLS)) u_fill (
		.clk(clk), .we(fill_we), .addr(fill_addr),
		.wdata(fill_wdata), .rdata(fill_rdata)
	);

	ugb_ram #(.WIDTH(STORE_BITS), .DEPTH(NUM_SLOTS)) u_entries (
		.clk(clk), .we(ent_we), .addr(ent_addr),
		.wdata(ent_wdata), .rdata(ent_rdata)
	);

	// divider for position / cell width
	logic                div_start, div_done;
	logic [MAG_BITS-1:0] div_quo;
	logic [POS_BITS-1:0] div_pos;
	logic [MAG_BITS-1:0] div_dividend;

	assign div_pos = div_y_q ? py_q : px_q;
	// x starts straight from the input port, y once x is done
	assign div_dividend = (state_q == S_IDLE) ? pos_x[MAG_BITS-1:0] : py_q[MAG_BITS-1:0];

	ugb_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_dividend), .divisor(width_eff),
		.done(div_done), .quotient(div_quo)
	);

	// clamped coordinate from the quotient
	logic [6:0]  dim;
	logic [5:0]  coord_clamped;
	always_comb begin
		dim = div_y_q ? rows_eff : cols_eff;
		if (div_pos[POS_BITS-1]) coord_clamped = 6'd0;
		else if (div_quo >= MAG_BITS'(dim)) coord_clamped = 6'(dim - 7'd1);
		else coord_clamped = div_quo[5:0];
	end

	// neighbor cell of current offsets, clamped
	logic [6:0] nc, nr;
	logic [CELL_BITS-1:0] ncell, bcell;
	always_comb begin
		nc = 7'(ccol_q) + 7'(dx_q) - 7'd1;
		nr = 7'(crow_q) + 7'(dy_q) - 7'd1;
		if (nc[6]) nc = 7'd0;
		else if (nc >= cols_eff) nc = cols_eff - 7'd1;
		if (nr[6]) nr = 7'd0;
		else if (nr >= rows_eff) nr = rows_eff - 7'd1;
		ncell = CELL_BITS'(32'(nr) * MAX_COLUMNS + 32'(nc));
		bcell = CELL_BITS'(32'(brow_q) * MAX_COLUMNS + 32'(bcol_q));
	end

	logic [SLOT_BITS-1:0] slot_addr;
	assign slot_addr = SLOT_BITS'(32'(cell_q) * CELL_CAPACITY + 32'(slot_q));

	logic in_xfer, out_xfer, out_free;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign out_free = !out_valid_q || out_ready;

	// output load controls and pending final status
	logic       load_out;
	logic [15:0] load_id;
	logic [2:0] load_st;
	logic       load_last;
	logic [2:0] fin_st_d, fin_st_q;

	// sequencer
	always_comb begin
		state_d   = state_q;
		fill_we   = 1'b0;
		fill_addr = cell_q;
		fill_wdata = '0;
		ent_we    = 1'b0;
		ent_addr  = slot_addr;
		ent_wdata = id_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		load_id   = '0;
		load_st   = ST_OK;
		load_last = 1'b0;
		fin_st_d  = fin_st_q;
		in_ready  = (state_q == S_IDLE);
		unique case (state_q)
			S_INIT: begin
				// fill memory clearing pass after reset, no result
				fill_we   = 1'b1;
				fill_addr = clr_q[CELL_BITS-1:0];
				if (clr_q == (CELL_BITS+1)'(NUM_CELLS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_CLEAR: begin
				fill_we   = 1'b1;
				fill_addr = clr_q[CELL_BITS-1:0];
				if (clr_q == (CELL_BITS+1)'(NUM_CELLS - 1)) begin
					state_d = S_FINISH;
				end
			end
			S_IDLE: begin
				if (in_xfer) begin
					fin_st_d = ST_OK;
					unique case (op_t'(operation))
						OP_CLEAR: state_d = S_CLEAR;
						OP_ADD: begin
							state_d = S_DIV;
							div_start = 1'b1;
						end
						OP_NEIGHBOR: begin
							if (result_limit == 6'd0) begin
								fin_st_d = ST_ZERO;
								state_d  = S_FINISH;
							end else begin
								state_d   = S_DIV;
								div_start = 1'b1;
							end
						end
						OP_BUCKET: begin
							if (result_limit == 6'd0) begin
								fin_st_d = ST_ZERO;
								state_d  = S_FINISH;
							end else begin
								state_d = S_DISPATCH;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_DIV: begin
				if (div_done && div_y_q) begin
					state_d = S_DISPATCH;
				end else if (div_done) begin
					div_start = 1'b1;
				end
			end
			S_DISPATCH: begin
				if (op_q == OP_BUCKET &&
				    (7'(brow_q) >= rows_eff || 7'(bcol_q) >= cols_eff)) begin
					fin_st_d = ST_RANGE;
					state_d  = S_FINISH;
				end else begin
					state_d = S_FILL_RD;
				end
			end
			S_FILL_RD: begin
				fill_addr = (op_q == OP_NEIGHBOR) ? ncell :
				            (op_q == OP_BUCKET) ? bcell :
				            CELL_BITS'(32'(crow_q) * MAX_COLUMNS + 32'(ccol_q));
				state_d = S_FILL_WAIT;
			end
			S_FILL_WAIT: state_d = S_FILL_USE;
			S_FILL_USE: begin
				if (op_q == OP_ADD) begin
					if (32'(fill_rdata) >= CELL_CAPACITY) begin
						fin_st_d = ST_FULL;
					end else begin
						fill_we    = 1'b1;
						fill_wdata = fill_rdata + FILL_BITS'(1);
						ent_we     = 1'b1;
						ent_addr   = SLOT_BITS'(32'(cell_q) * CELL_CAPACITY
						             + 32'(fill_rdata));
					end
					state_d = S_FINISH;
				end else if (op_q == OP_BUCKET) begin
					if (7'(fill_rdata) > 7'(limit_q)) fin_st_d = ST_LIMIT;
					state_d = S_ENT_RD;
				end else begin
					if (n_q + 7'(fill_rdata) > 7'(limit_q)) begin
						fin_st_d = ST_LIMIT;
						state_d  = S_FINISH;
					end else begin
						state_d = S_ENT_RD;
					end
				end
			end
			S_ENT_RD: begin
				if (slot_q == cnt_q) begin
					if (op_q == OP_NEIGHBOR && !(dx_q == 2'd2 && dy_q == 2'd2)) begin
						state_d = S_FILL_RD;
					end else begin
						state_d = S_FINISH;
					end
				end else begin
					state_d = S_ENT_WAIT;
				end
			end
			S_ENT_WAIT: state_d = S_OUT_WAIT;
			S_OUT_WAIT: begin
				// hold the previous result until the next one or finish knows last
				if (out_free) begin
					load_out = 1'b1;
					load_id  = 16'(ent_rdata);
					state_d  = S_ENT_RD;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_last = 1'b1;
					load_st   = fin_st_q;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// an id waits in a staging register so that the final one can carry last
	logic        hold_q;
	logic [15:0] hold_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			hold_q      <= 1'b0;
			edge_len_q  <= 16'd256;
			columns_q   <= 6'd32;
			rows_q      <= 6'd32;
			fin_st_q    <= ST_OK;
		end else begin
			state_q  <= state_d;
			fin_st_q <= fin_st_d;
			if (state_q == S_CLEAR || state_q == S_INIT) clr_q <= clr_q + 1'b1;
			if (in_xfer) begin
				clr_q    <= '0;
				hold_q   <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (reg_idx_t'(cfg_index))
					REG_EDGE_LEN: edge_len_q <= cfg_data;
					REG_COLUMNS:  columns_q <= cfg_data[5:0];
					REG_ROWS:     rows_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (load_out && (load_last || hold_q)) out_valid_q <= 1'b1;
			else if (out_xfer) out_valid_q <= 1'b0;
			if (load_out) begin
				hold_q <= !load_last;
			end
		end
	end

	// output register loads either the staged id or the closing result
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (load_last) begin
				out_id_q   <= hold_q ? hold_id_q : 16'd0;
				out_idv_q  <= hold_q;
				out_st_q   <= load_st;
				out_last_q <= 1'b1;
			end else begin
				out_id_q   <= hold_id_q;
				out_idv_q  <= 1'b1;
				out_st_q   <= ST_OK;
				out_last_q <= 1'b0;
				hold_id_q  <= load_id;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= op_t'(operation);
			id_q    <= element_id[STORE_BITS-1:0];
			px_q    <= pos_x;
			py_q    <= pos_y;
			brow_q  <= bucket_row;
			bcol_q  <= bucket_col;
			limit_q <= result_limit;
			div_y_q <= 1'b0;
			dx_q    <= 2'd0;
			dy_q    <= 2'd0;
			n_q     <= '0;
		end
		if (state_q == S_DIV && div_done) begin
			if (div_y_q) crow_q <= ROW_BITS'(coord_clamped);
			else ccol_q <= COL_BITS'(coord_clamped);
			div_y_q <= 1'b1;
		end
		if (state_q == S_FILL_RD) cell_q <= fill_addr;
		if (state_q == S_FILL_USE) begin
			slot_q <= '0;
			if (op_q == OP_BUCKET && 7'(fill_rdata) > 7'(limit_q)) cnt_q <= limit_q[2:0];
			else cnt_q <= fill_rdata;
			if (op_q == OP_NEIGHBOR) n_q <= n_q + 7'(fill_rdata);
		end
		if (state_q == S_ENT_RD && slot_q == cnt_q && op_q == OP_NEIGHBOR) begin
			if (dy_q == 2'd2) begin
				dy_q <= 2'd0;
				dx_q <= dx_q + 2'd1;
			end else begin
				dy_q <= dy_q + 2'd1;
			end
		end
		if (state_q == S_OUT_WAIT && out_free) slot_q <= slot_q + FILL_BITS'(1);
	end

	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign found_id  = out_id_q;
	assign id_valid  = out_idv_q;
	assign status    = out_st_q;
	assign last      = out_last_q;

	// a valid result without an id must be the final one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !id_valid |-> last)
		else $error("id-less result must be final");
	// status other than ok only on the final result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_OK)
		else $error("status on a non-final result");
	// no new item while the sequencer is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("item accepted while busy");
endmodule

// ----- sim/uniform_grid_broadphase_test.sv -----
// self-checking testbench for the uniform grid broadphase
`timescale 1ns / 100ps

module uniform_grid_broadphase_test;
	import ugb_pkg::*;

	localparam int NCOLS = 32;
	localparam int NROWS = 32;
	localparam int CAP = 7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SQUEEZE_CYCLES = 400;

	typedef struct {
		op_t op;
		logic [15:0] id;
		logic signed [19:0] px;
		logic signed [19:0] py;
		logic [5:0] brow;
		logic [5:0] bcol;
		logic [5:0] lim;
	} grid_op_t;

	typedef struct {
		logic [15:0] id;
		logic vld;
		status_t st;
		logic lst;
	} grid_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = OP_CLEAR;
	logic [15:0] element_id = '0;
	logic signed [19:0] pos_x = '0;
	logic signed [19:0] pos_y = '0;
	logic [5:0] bucket_row = '0;
	logic [5:0] bucket_col = '0;
	logic [5:0] result_limit = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] found_id;
	logic id_valid;
	logic [2:0] status;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_EDGE_LEN;
	logic [15:0] cfg_data = '0;

	uniform_grid_broadphase dut (.*);

	initial forever #4 clk = ~clk;

	// shadow copy of the grid and its registers
	int unsigned cw_shadow = 256;
	int unsigned cols_shadow = 32;
	int unsigned rows_shadow = 32;
	logic [2:0] fill_shadow [NCOLS*NROWS];
	logic [15:0] slot_shadow [NCOLS*NROWS*CAP];

	grid_op_t pending_ops[$];
	grid_result_t expected_results[$];
	grid_op_t cur_op;

	int errors = 0;
	int results_seen = 0;
	int ops_sent = 0;
	int cycles = 0;
	logic quiet = 1'b0;
	logic squeeze_req = 1'b0;

	function automatic int unsigned cell_coord(logic signed [19:0] p, int unsigned count);
		int unsigned w;
		int unsigned q;
		w = (cw_shadow == 0) ? 1 : cw_shadow;
		if (p[19]) return 0;
		q = int'(p[18:0]) / w;
		return (q >= count) ? count - 1 : q;
	endfunction

	function automatic grid_result_t mk_res(logic [15:0] id, logic v, status_t st, logic l);
		grid_result_t r;
		r.id = id; r.vld = v; r.st = st; r.lst = l;
		return r;
	endfunction

	// work out the results of one transferred operation and update the shadow grid
	task automatic predict_grid_op(grid_op_t g);
		int unsigned cols;
		int unsigned rows;
		int unsigned cell_ix;
		int unsigned cnt;
		int c;
		int r;
		int col;
		int row;
		int n;
		grid_result_t found[$];
		status_t fin;
		cols = (cols_shadow == 0) ? 1 : (cols_shadow > NCOLS ? NCOLS : cols_shadow);
		rows = (rows_shadow == 0) ? 1 : (rows_shadow > NROWS ? NROWS : rows_shadow);
		fin = ST_OK;
		if (g.op == OP_CLEAR) begin
			foreach (fill_shadow[i]) fill_shadow[i] = '0;
			expected_results.push_back(mk_res('0, 1'b0, ST_OK, 1'b1));
			return;
		end
		if (g.op == OP_ADD) begin
			cell_ix = cell_coord(g.py, rows) * NCOLS + cell_coord(g.px, cols);
			if (fill_shadow[cell_ix] >= CAP) begin
				expected_results.push_back(mk_res('0, 1'b0, ST_FULL, 1'b1));
			end else begin
				slot_shadow[cell_ix*CAP + fill_shadow[cell_ix]] = g.id;
				fill_shadow[cell_ix] = 3'(fill_shadow[cell_ix] + 1);
				expected_results.push_back(mk_res('0, 1'b0, ST_OK, 1'b1));
			end
			return;
		end
		if (g.lim == 0) begin
			expected_results.push_back(mk_res('0, 1'b0, ST_ZERO, 1'b1));
			return;
		end
		if (g.op == OP_NEIGHBOR) begin
			col = cell_coord(g.px, cols);
			row = cell_coord(g.py, rows);
			n = 0;
			// column offset outer, row offset inner; edges clamp and repeat
			for (int dx = -1; dx < 2 && fin == ST_OK; dx++) begin
				for (int dy = -1; dy < 2 && fin == ST_OK; dy++) begin
					c = col + dx; r = row + dy;
					if (c >= int'(cols)) c = int'(cols) - 1;
					if (c < 0) c = 0;
					if (r >= int'(rows)) r = int'(rows) - 1;
					if (r < 0) r = 0;
					cell_ix = r * NCOLS + c;
					cnt = fill_shadow[cell_ix];
					if (n + cnt > g.lim) fin = ST_LIMIT;
					else begin
						for (int k = 0; k < cnt; k++)
							found.push_back(mk_res(slot_shadow[cell_ix*CAP+k], 1'b1,
								ST_OK, 1'b0));
						n += cnt;
					end
				end
			end
		end else begin
			if (g.brow >= rows || g.bcol >= cols) begin
				expected_results.push_back(mk_res('0, 1'b0, ST_RANGE, 1'b1));
				return;
			end
			cell_ix = g.brow * NCOLS + g.bcol;
			cnt = fill_shadow[cell_ix];
			if (cnt > g.lim) begin
				cnt = g.lim;
				fin = ST_LIMIT;
			end
			for (int k = 0; k < cnt; k++)
				found.push_back(mk_res(slot_shadow[cell_ix*CAP+k], 1'b1, ST_OK, 1'b0));
		end
		if (found.size() == 0) found.push_back(mk_res('0, 1'b0, fin, 1'b1));
		else begin
			found[$].st = fin;
			found[$].lst = 1'b1;
		end
		foreach (found[i]) expected_results.push_back(found[i]);
	endtask

	// driver: offers pending operations, with random gaps between them unless quiet
	int gap_left = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_grid_op(cur_op);
			ops_sent <= ops_sent + 1;
		end
		if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				cur_op = pending_ops.pop_front();
				operation <= cur_op.op;
				element_id <= cur_op.id;
				pos_x <= cur_op.px;
				pos_y <= cur_op.py;
				bucket_row <= cur_op.brow;
				bucket_col <= cur_op.bcol;
				result_limit <= cur_op.lim;
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 8);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall bursts plus one long hold-off to back up the block
	int stall_left = 0;
	int hold_left = 0;
	logic squeeze_done = 1'b0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $realtime,
				expected_results.size());
			$display("Verification failed");
			$finish;
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (squeeze_req && !squeeze_done) begin
			squeeze_done <= 1'b1;
			hold_left <= SQUEEZE_CYCLES;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: each result transfer is checked against the oldest prediction
	always @(posedge clk) begin
		grid_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result id=%h valid=%b status=%0d last=%b",
					$realtime, found_id, id_valid, status, last);
				errors <= errors + 1;
			end else begin
				want = expected_results.pop_front();
				if (found_id !== want.id || id_valid !== want.vld ||
						status !== want.st || last !== want.lst) begin
					$display("%0t: mismatch expected id=%h valid=%b status=%0d last=%b",
						$realtime, want.id, want.vld, want.st, want.lst);
					$display("%0t:          actual   id=%h valid=%b status=%0d last=%b",
						$realtime, found_id, id_valid, status, last);
					errors <= errors + 1;
				end
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		cfg_valid <= 1'b0;
		case (idx)
			REG_EDGE_LEN: cw_shadow = data;
			REG_COLUMNS: cols_shadow = data[5:0];
			default: rows_shadow = data[5:0];
		endcase
	endtask

	task automatic wait_idle();
		forever begin
			@(posedge clk);
			if (pending_ops.size() == 0 && !in_valid && expected_results.size() == 0) break;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic push_op(op_t op, logic [15:0] id, logic signed [19:0] px,
			logic signed [19:0] py, logic [5:0] br, logic [5:0] bc, logic [5:0] lim);
		grid_op_t g;
		g.op = op; g.id = id; g.px = px; g.py = py; g.brow = br; g.bcol = bc; g.lim = lim;
		pending_ops.push_back(g);
	endtask

	// position mostly inside the active grid, sometimes negative or anywhere
	function automatic logic signed [19:0] rand_pos(int unsigned count);
		int unsigned w;
		int unsigned v;
		int unsigned pick;
		w = (cw_shadow == 0) ? 1 : cw_shadow;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			v = $urandom_range(0, count - 1) * w + $urandom_range(0, w - 1);
			if (v > 20'h7FFFF) v = $urandom_range(0, 20'h7FFFF);
			return v[19:0];
		end
		if (pick < 9) return 20'($urandom());
		return 20'(-int'($urandom_range(1, 20'h80000)));
	endfunction

	task automatic random_ops(int count);
		int unsigned cols;
		int unsigned rows;
		int unsigned pick;
		logic [5:0] lim;
		logic [5:0] br;
		logic [5:0] bc;
		cols = (cols_shadow == 0) ? 1 : (cols_shadow > NCOLS ? NCOLS : cols_shadow);
		rows = (rows_shadow == 0) ? 1 : (rows_shadow > NROWS ? NROWS : rows_shadow);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			lim = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
			if ($urandom_range(0, 4) == 0) begin
				br = 6'($urandom()); bc = 6'($urandom());
			end else begin
				br = 6'($urandom_range(0, rows - 1)); bc = 6'($urandom_range(0, cols - 1));
			end
			if (pick < 3)
				push_op(OP_CLEAR, 16'($urandom()), 20'($urandom()), 20'($urandom()),
					br, bc, lim);
			else if (pick < 50)
				push_op(OP_ADD, 16'($urandom()), rand_pos(cols), rand_pos(rows), br, bc, lim);
			else if (pick < 75)
				push_op(OP_NEIGHBOR, 16'($urandom()), rand_pos(cols), rand_pos(rows),
					br, bc, lim);
			else
				push_op(OP_BUCKET, 16'($urandom()), rand_pos(cols), rand_pos(rows),
					br, bc, lim);
		end
	endtask

	initial begin
		foreach (fill_shadow[i]) fill_shadow[i] = '0;
		foreach (slot_shadow[i]) slot_shadow[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every operation and the corner cases at reset settings
		push_op(OP_CLEAR, 16'h0, 20'sh0, 20'sh0, 6'd0, 6'd0, 6'd0);
		push_op(OP_ADD, 16'hFFFF, 20'sh0, 20'sh0, 6'd0, 6'd0, 6'd63);
		push_op(OP_ADD, 16'h0000, 20'sh7FFFF, 20'sh7FFFF, 6'd0, 6'd0, 6'd0);
		push_op(OP_ADD, 16'h1234, -20'sd524288, -20'sd1, 6'd0, 6'd0, 6'd0);
		for (int k = 0; k < 6; k++)
			push_op(OP_ADD, 16'(16'hA000 + k), 20'sd300, 20'sd5, 6'd0, 6'd0, 6'd0);
		push_op(OP_NEIGHBOR, 16'h0, 20'sh0, 20'sh0, 6'd0, 6'd0, 6'd63);
		push_op(OP_NEIGHBOR, 16'h0, 20'sh0, 20'sh0, 6'd0, 6'd0, 6'd0);
		push_op(OP_NEIGHBOR, 16'h0, 20'sh0, 20'sh0, 6'd0, 6'd0, 6'd3);
		push_op(OP_NEIGHBOR, 16'h0, 20'sh7FFFF, 20'sh7FFFF, 6'd0, 6'd0, 6'd63);
		push_op(OP_NEIGHBOR, 16'h0, 20'sd4000, 20'sd4000, 6'd0, 6'd0, 6'd63);
		push_op(OP_BUCKET, 16'h0, 20'sh0, 20'sh0, 6'd0, 6'd0, 6'd63);
		push_op(OP_BUCKET, 16'h0, 20'sh0, 20'sh0, 6'd0, 6'd1, 6'd2);
		push_op(OP_BUCKET, 16'h0, 20'sh0, 20'sh0, 6'd40, 6'd0, 6'd5);
		push_op(OP_BUCKET, 16'h0, 20'sh0, 20'sh0, 6'd0, 6'd63, 6'd5);
		push_op(OP_BUCKET, 16'h0, 20'sh0, 20'sh0, 6'd63, 6'd63, 6'd0);
		push_op(OP_BUCKET, 16'h0, 20'sh0, 20'sh0, 6'd9, 6'd9, 6'd1);
		push_op(OP_BUCKET, 16'h0, 20'sh0, 20'sh0, 6'd31, 6'd31, 6'd63);
		wait_idle();

		// small grid, narrow cells: cells fill up and edges repeat
		write_reg(REG_EDGE_LEN, 16'd16);
		write_reg(REG_COLUMNS, 16'd4);
		write_reg(REG_ROWS, 16'd3);
		random_ops(30);
		wait_idle();

		// widest cells with the long receiver hold-off while items keep coming
		write_reg(REG_EDGE_LEN, 16'hFFFF);
		write_reg(REG_COLUMNS, 16'd32);
		write_reg(REG_ROWS, 16'd32);
		squeeze_req <= 1'b1;
		random_ops(30);
		wait_idle();

		// out of range counts: zero acts as one, sixty-three as the maximum
		write_reg(REG_EDGE_LEN, 16'd1);
		write_reg(REG_COLUMNS, 16'd0);
		write_reg(REG_ROWS, 16'd63);
		random_ops(25);
		wait_idle();

		// zero cell width with a single cell, then a final stretch with no idling
		write_reg(REG_EDGE_LEN, 16'd0);
		write_reg(REG_COLUMNS, 16'd1);
		write_reg(REG_ROWS, 16'd1);
		random_ops(10);
		wait_idle();
		write_reg(REG_EDGE_LEN, 16'd24);
		write_reg(REG_COLUMNS, 16'd3);
		write_reg(REG_ROWS, 16'd2);
		quiet <= 1'b1;
		random_ops(20);
		wait_idle();

		$display("covered %0d operations over six register settings, %0d results checked",
			ops_sent, results_seen);
		$display("settings included min and max cell width and out of range grid counts");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
